>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lzw_pkg.sv
// Shared constants and types of the LZW byte encoder.
package lzw_pkg;

	localparam int DICT_SIZE  = 4096;
	localparam int CODE_LIMIT = (DICT_SIZE < 4096) ? DICT_SIZE : 4096;
	localparam int ADDR_W     = $clog2(CODE_LIMIT);
	localparam int CODE_W     = 12;
	localparam int BYTE_W     = 8;
	localparam int NEXT_W     = 13;
	localparam int NODE_W     = CODE_W + BYTE_W;
	localparam int FIRST_CODE = 256;
	localparam int BYTE_MASK  = 255;
	localparam int OUT_DATA_W = 16;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Code 0 never appears as a child, so it marks an empty link.
	localparam code_t NULL_CODE = '0;

endpackage

>>> rtl/lzw_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module lzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lzw_byte_encoder_unit.sv
// Top level of the LZW byte encoder: trie walk over head and node memories.
//
//  channel | beat          | tdata (low bit up)      | tlast
//  --------+---------------+-------------------------+----------------------
//  s_axis  | one raw byte  | data_byte[7:0]          | last_byte
//  m_axis  | one code      | code[11:0], zero [15:12]| end_of_stream
//
// A byte that starts a stream is only taken as the prefix. Any other byte reads
// the prefix's head, then visits its siblings in the node memory (one read per cycle,
// up to 256); a miss adds a step to emit the prefix, and one more to learn a new code.
// A last byte adds a step to emit the final code.
// Reset clears the control state only; the memories hold no valid data and
// need no clearing pass, since each stream rebuilds its trie from code 256.
// A full output register stalls the sequencer only where it must emit a code.
module lzw_byte_encoder_unit import lzw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic                  s_axis_tlast,  // last_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [11:0] code, [15:12] zero
	output logic                  m_axis_tlast   // end_of_stream
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_NODE,
		ST_MISS,
		ST_LINK,
		ST_LAST
	} state_t;

	state_t                state_q;
	code_t                 prefix_q;
	logic                  pv_q;
	logic [NEXT_W-1:0]     next_q;
	byte_t                 byte_q;
	logic                  last_q;
	code_t                 cur_q;
	code_t                 head_q;
	logic [FIRST_CODE-1:0] hv_q;
	code_t                 out_code_q;
	logic                  out_valid_q;
	logic                  out_last_q;

	logic              head_we;
	logic [ADDR_W-1:0] head_waddr;
	code_t             head_wdata;
	logic              head_re;
	code_t             head_rdata;
	logic              node_we;
	logic [ADDR_W-1:0] node_waddr;
	logic [NODE_W-1:0] node_wdata;
	logic              node_re;
	logic [ADDR_W-1:0] node_raddr;
	logic [NODE_W-1:0] node_rdata;

	logic  in_beat;
	logic  slot_free;
	logic  out_load;
	logic  prefix_is_byte;
	code_t head_eff;
	code_t node_sib;
	byte_t node_byte;
	logic  dict_room;

	assign s_axis_tready  = (state_q == ST_IDLE);
	assign in_beat        = s_axis_tvalid && s_axis_tready;
	assign slot_free      = !out_valid_q || m_axis_tready;
	assign out_load       = ((state_q == ST_MISS) || (state_q == ST_LAST)) && slot_free;
	assign prefix_is_byte = (prefix_q[CODE_W-1:BYTE_W] == '0);
	assign dict_room      = (next_q < NEXT_W'(CODE_LIMIT));
	// Single-byte codes carry no head until a child is linked in this stream.
	assign head_eff = (prefix_is_byte && !hv_q[prefix_q[BYTE_W-1:0]]) ? NULL_CODE : head_rdata;
	assign node_sib  = node_rdata[NODE_W-1:BYTE_W];
	assign node_byte = node_rdata[BYTE_W-1:0];

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-CODE_W){1'b0}}, out_code_q};
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		head_re    = 1'b0;
		head_we    = 1'b0;
		head_waddr = prefix_q[ADDR_W-1:0];
		head_wdata = NULL_CODE;
		node_re    = 1'b0;
		node_raddr = head_eff[ADDR_W-1:0];
		node_we    = 1'b0;
		node_waddr = next_q[ADDR_W-1:0];
		node_wdata = {head_q, byte_q};
		case (state_q)
			ST_IDLE: begin
				head_re = in_beat && pv_q;
			end
			ST_HEAD: begin
				node_re = (head_eff != NULL_CODE);
			end
			ST_NODE: begin
				node_re    = (node_byte != byte_q) && (node_sib != NULL_CODE);
				node_raddr = node_sib[ADDR_W-1:0];
			end
			ST_MISS: begin
				// New code starts with no children and heads the prefix's list.
				node_we    = slot_free && dict_room;
				head_we    = slot_free && dict_room;
				head_waddr = next_q[ADDR_W-1:0];
			end
			ST_LINK: begin
				head_we    = 1'b1;
				head_wdata = next_q[CODE_W-1:0];
			end
			default: ;
		endcase
	end

	lzw_ram #(.WIDTH(CODE_W), .DEPTH(CODE_LIMIT)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (head_re),
		.raddr (prefix_q[ADDR_W-1:0]),
		.rdata (head_rdata)
	);

	lzw_ram #(.WIDTH(NODE_W), .DEPTH(CODE_LIMIT)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prefix_q    <= NULL_CODE;
			pv_q        <= 1'b0;
			next_q      <= NEXT_W'(FIRST_CODE);
			byte_q      <= '0;
			last_q      <= 1'b0;
			cur_q       <= NULL_CODE;
			head_q      <= NULL_CODE;
			hv_q        <= '0;
			out_code_q  <= NULL_CODE;
			out_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						byte_q <= s_axis_tdata;
						last_q <= s_axis_tlast;
						if (!pv_q) begin
							prefix_q <= CODE_W'(s_axis_tdata);
							pv_q     <= 1'b1;
							state_q  <= s_axis_tlast ? ST_LAST : ST_IDLE;
						end else begin
							state_q <= ST_HEAD;
						end
					end
				end
				ST_HEAD: begin
					head_q <= head_eff;
					cur_q  <= head_eff;
					state_q <= (head_eff == NULL_CODE) ? ST_MISS : ST_NODE;
				end
				ST_NODE: begin
					if (node_byte == byte_q) begin
						prefix_q <= cur_q;
						state_q  <= last_q ? ST_LAST : ST_IDLE;
					end else if (node_sib == NULL_CODE) begin
						state_q <= ST_MISS;
					end else begin
						cur_q <= node_sib;
					end
				end
				ST_MISS: begin
					if (slot_free) begin
						out_code_q <= prefix_q;
						out_last_q <= 1'b0;
						if (dict_room) begin
							state_q <= ST_LINK;
						end else begin
							prefix_q <= CODE_W'(byte_q);
							state_q  <= last_q ? ST_LAST : ST_IDLE;
						end
					end
				end
				ST_LINK: begin
					if (prefix_is_byte) begin
						hv_q[prefix_q[BYTE_W-1:0]] <= 1'b1;
					end
					next_q   <= next_q + NEXT_W'(1);
					prefix_q <= CODE_W'(byte_q);
					state_q  <= last_q ? ST_LAST : ST_IDLE;
				end
				ST_LAST: begin
					if (slot_free) begin
						out_code_q <= prefix_q;
						out_last_q <= 1'b1;
						// Start the next stream with a fresh dictionary.
						prefix_q <= NULL_CODE;
						pv_q     <= 1'b0;
						next_q   <= NEXT_W'(FIRST_CODE);
						hv_q     <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/lzw_checker.sv
// Port-level assertions of the LZW byte encoder, bound to the top level.
`include "assert_macros.svh"

module lzw_checker import lzw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [BYTE_W-1:0]     s_axis_tdata,
	input logic                  s_axis_tlast,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	logic in_last_beat;
	logic out_stall;

	assign in_last_beat = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_stall    = m_axis_tvalid && !m_axis_tready;

	// Hold a stalled code beat.
	`ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "output beat dropped while stalled")
	`ASSERT_NEXT(a_out_stable, out_stall, $stable({m_axis_tlast, m_axis_tdata}), "beat changed")
	// Codes never reach the padding bits.
	`ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:CODE_W] == '0, "code padding not zero")
	// A last byte always leaves a flush to do, so the input side must close.
	`ASSERT_NEXT(a_last_busy, in_last_beat, !s_axis_tready, "input ready right after a last byte")

endmodule

bind lzw_byte_encoder_unit lzw_checker u_lzw_checker (.*);

>>> test/lzw_byte_encoder_unit_checker.sv
// Checker for the LZW byte encoder: predicts emitted codes and compares the output beats.
module lzw_code_checker import lzw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
	input  logic                  s_axis_tlast,  // last_byte
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // [11:0] code, [15:12] zero
	input  logic                  m_axis_tlast,  // end_of_stream
	output int                    fail_count,
	output int                    pending_codes
);

	typedef struct packed {
		logic  eos;
		code_t code;
	} code_beat_t;

	// Encoder state as seen from the byte stream.
	code_t             cur_prefix     = '0;
	bit                have_prefix    = 1'b0;
	logic [NEXT_W-1:0] free_code      = NEXT_W'(FIRST_CODE);
	code_t             pair_code[int];           // {prefix, byte} -> learned code

	code_beat_t        owed_codes[$];
	code_beat_t        oldest;
	int                errors         = 0;

	initial begin
		fail_count    = 0;
		pending_codes = 0;
	end

	// Advance the encoder by one byte and queue the codes it emits.
	function automatic void encode_byte(input byte_t b, input logic fin);
		int key;
		key = int'({cur_prefix, b});
		if (!have_prefix) begin
			cur_prefix  = code_t'(b);
			have_prefix = 1'b1;
		end else if (pair_code.exists(key)) begin
			cur_prefix = pair_code[key];
		end else begin
			owed_codes.push_back('{eos: 1'b0, code: cur_prefix});
			// stop learning once the code space is used up
			if (free_code < NEXT_W'(CODE_LIMIT)) begin
				pair_code[key] = free_code[CODE_W-1:0];
				free_code      = free_code + NEXT_W'(1);
			end
			cur_prefix = code_t'(b);
		end
		if (fin) begin
			owed_codes.push_back('{eos: 1'b1, code: cur_prefix});
			cur_prefix  = '0;
			have_prefix = 1'b0;
			free_code   = NEXT_W'(FIRST_CODE);
			pair_code.delete();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_prefix  = '0;
			have_prefix = 1'b0;
			free_code   = NEXT_W'(FIRST_CODE);
			pair_code.delete();
			owed_codes.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_codes.size() == 0) begin
					$display("%0t unexpected code beat: expected none, got code %0d eos %0b",
						$time, m_axis_tdata[CODE_W-1:0], m_axis_tlast);
					errors++;
				end else begin
					oldest = owed_codes.pop_front();
					if (m_axis_tdata !== OUT_DATA_W'(oldest.code) ||
							m_axis_tlast !== oldest.eos) begin
						$display("%0t code beat: expected tdata %h eos %0b, got tdata %h eos %0b",
							$time, OUT_DATA_W'(oldest.code), oldest.eos,
							m_axis_tdata, m_axis_tlast);
						errors++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				encode_byte(s_axis_tdata, s_axis_tlast);
		end
		fail_count    <= errors;
		pending_codes <= owed_codes.size();
	end

endmodule

>>> test/lzw_byte_encoder_unit_tb.sv
// Testbench top for the LZW byte encoder: clock, reset, byte streams and verdict.
module lzw_byte_encoder_unit_tb;
	import lzw_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN       = 600;

	typedef enum int {ANY_BYTES, FEW_BYTES, ONE_BYTE} byte_mix_t;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  s_axis_tvalid  = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata   = '0;
	logic                  s_axis_tlast   = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int fail_count;
	int pending_codes;
	int cycles     = 0;
	int bytes_sent = 0;
	bit calm       = 1'b0;   // no idling on either side while set

	lzw_byte_encoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lzw_code_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending_codes (pending_codes)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lzw_byte_encoder_unit: mismatch");
			$finish;
		end
	end

	// Code sink: random stall before each beat.
	initial begin : code_sink
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_byte(input byte_t b, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Hold the byte channel idle until every predicted code has come out.
	task automatic wait_for_codes();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_codes != 0) @(posedge clk);
	endtask

	task automatic send_stream(input int len, input byte_mix_t mix);
		byte_t base;
		byte_t b;
		int    span;
		base = byte_t'($urandom_range(0, 255));
		span = $urandom_range(1, 3);
		for (int i = 0; i < len; i++) begin
			case (mix)
				ANY_BYTES: b = byte_t'($urandom_range(0, 255));
				FEW_BYTES: b = base + byte_t'($urandom_range(0, span));
				default:   b = base;
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	task automatic send_random_streams(input int quota);
		int        target;
		int        len;
		byte_mix_t mix;
		target = bytes_sent + quota;
		while (bytes_sent < target) begin
			calm = ($urandom_range(0, 3) == 0);
			len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			case ($urandom_range(0, 5))
				0, 1:    mix = ANY_BYTES;
				5:       mix = ONE_BYTE;
				default: mix = FEW_BYTES;
			endcase
			send_stream(len, mix);
		end
		calm = 1'b0;
	endtask

	initial begin : byte_source
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte streams at both ends of the byte range
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// run of zeros: the final byte hits a learned pair, one code on the last beat
		for (int i = 0; i < 6; i++)
			send_byte(8'h00, i == 5);
		// alternating 0xFF / 0x00: the final byte hits a learned pair, one code on the last beat
		for (int i = 0; i < 7; i++)
			send_byte((i % 2) ? 8'h00 : 8'hFF, i == 6);
		calm = 1'b1;
		for (int i = 0; i < 5; i++)
			send_byte((i % 2) ? 8'h55 : 8'hAA, 1'b0);
		calm = 1'b0;
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		wait_for_codes();

		send_random_streams(200);
		wait_for_codes();
		send_random_streams(200);

		wait_for_codes();
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("lzw_byte_encoder_unit: match");
		else
			$display("lzw_byte_encoder_unit: mismatch");
		$finish;
	end

endmodule
